>>> hw/rtl/eight_bit_cpu_instruction_executor_defines.svh
// assertion macros for the cpu executor
`ifndef EIGHT_BIT_CPU_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define EIGHT_BIT_CPU_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define EBC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EBC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hw/rtl/ebc_pkg.sv
package ebc_pkg;
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_EXEC  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [15:0] SP_RESET = 16'hf000;
  localparam logic [7:0] RST_MASK = 8'h38;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  data;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_F0, ST_F1, ST_F2, ST_F3, ST_D0, ST_D1, ST_D2, ST_D3,
    ST_EXEC, ST_W0, ST_W1, ST_DONE
  } state_t;

  function automatic logic parity_even(input logic [7:0] v);
    return ~(^v);
  endfunction
endpackage

>>> hw/rtl/ebc_ram.sv
module ebc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/ebc_front.sv
module ebc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    func,
  input  logic [15:0]   address,
  input  logic [7:0]    data,
  output ebc_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_pop
);
  ebc_pkg::cmd_t slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push;

  assign in_ready = cnt_r != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd = slot_r[rp_r];
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= '{func: func, address: address, data: data};
    end
  end
endmodule

>>> hw/rtl/ebc_back.sv
module ebc_back #(
  parameter int MEM_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ebc_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_pc,
  output logic [15:0]   out_sp,
  output logic [7:0]    out_acc,
  output logic [15:0]   out_bc,
  output logic [15:0]   out_de,
  output logic [15:0]   out_hl,
  output logic [7:0]    out_psw,
  output logic [7:0]    out_read_data,
  output logic          out_unimplemented
);
  localparam int AW = $clog2(MEM_BYTES);

  ebc_pkg::state_t st_r, st_nxt;
  ebc_pkg::cmd_t cmd_r;
  logic [7:0] a_r, b_r, c_r, d_r, e_r, h_r, l_r;
  logic [15:0] sp_r, pc_r;
  logic fz_r, fs_r, fp_r, fc_r, fa_r;
  logic [7:0] op_r, b1_r, b2_r, d0_r;
  logic [7:0] rd_r;
  logic un_r;
  logic ov_r;

  logic we;
  logic [15:0] maddr;
  logic [7:0] wdata, rdata;

  ebc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(we), .addr(maddr[AW-1:0]), .wdata(wdata), .rdata(rdata)
  );

  // decode helpers
  logic [1:0] rp;
  logic [2:0] dst, src, cc;
  logic [15:0] hl, imm, pairv;
  logic ctrue;
  logic is_mov, is_alu, is_alui, is_lxi, is_inr, is_dcr, is_mvi;
  logic is_ret, is_jmpc, is_callc, is_rst, is_pop, is_push;
  logic need_d0, need_d1;
  logic [15:0] d0a;
  logic [1:0] nwr;
  logic [15:0] w0a, w1a;
  logic [7:0] w0d, w1d;
  logic callt;

  assign rp = op_r[5:4];
  assign dst = op_r[5:3];
  assign src = op_r[2:0];
  assign cc = op_r[5:3];
  assign hl = {h_r, l_r};
  assign imm = {b2_r, b1_r};

  always_comb begin
    case (rp)
      2'd0: pairv = {b_r, c_r};
      2'd1: pairv = {d_r, e_r};
      2'd2: pairv = hl;
      default: pairv = sp_r;
    endcase
    case (cc)
      3'd0: ctrue = !fz_r;
      3'd1: ctrue = fz_r;
      3'd2: ctrue = !fc_r;
      3'd3: ctrue = fc_r;
      3'd4: ctrue = !fp_r;
      3'd5: ctrue = fp_r;
      3'd6: ctrue = !fs_r;
      default: ctrue = fs_r;
    endcase
  end

  function automatic logic [7:0] rget(input logic [2:0] k, input logic [7:0] m,
                                      input logic [7:0] vb, input logic [7:0] vc,
                                      input logic [7:0] vd, input logic [7:0] ve,
                                      input logic [7:0] vh, input logic [7:0] vl,
                                      input logic [7:0] va);
    logic [7:0] r;
    case (k)
      3'd0: r = vb;
      3'd1: r = vc;
      3'd2: r = vd;
      3'd3: r = ve;
      3'd4: r = vh;
      3'd5: r = vl;
      3'd6: r = m;
      default: r = va;
    endcase
    return r;
  endfunction

  assign is_mov = op_r[7:6] == 2'b01 && op_r != 8'h76;
  assign is_alu = op_r[7:6] == 2'b10;
  assign is_alui = (op_r & 8'hc7) == 8'hc6;
  assign is_lxi = (op_r & 8'hcf) == 8'h01;
  assign is_inr = (op_r & 8'hc7) == 8'h04;
  assign is_dcr = (op_r & 8'hc7) == 8'h05;
  assign is_mvi = (op_r & 8'hc7) == 8'h06;
  assign is_ret = (op_r & 8'hc7) == 8'hc0 || op_r == 8'hc9;
  assign is_jmpc = (op_r & 8'hc7) == 8'hc2;
  assign is_callc = (op_r & 8'hc7) == 8'hc4;
  assign is_rst = (op_r & 8'hc7) == 8'hc7;
  assign is_pop = (op_r & 8'hcf) == 8'hc1;
  assign is_push = (op_r & 8'hcf) == 8'hc5;
  assign callt = (is_callc && ctrue) || op_r == 8'hcd;

  // data reads: d0 at d0a, d1 at d0a+1
  always_comb begin
    need_d0 = 1'b0;
    need_d1 = 1'b0;
    d0a = hl;
    if ((is_mov && src == 3'd6) || (is_alu && src == 3'd6)
        || ((is_inr || is_dcr) && dst == 3'd6)) begin
      need_d0 = 1'b1;
    end else if (op_r == 8'h0a || op_r == 8'h1a) begin
      need_d0 = 1'b1;
      d0a = pairv;
    end else if (op_r == 8'h3a) begin
      need_d0 = 1'b1;
      d0a = imm;
    end else if (op_r == 8'h2a) begin
      need_d0 = 1'b1;
      need_d1 = 1'b1;
      d0a = imm;
    end else if ((is_ret && (op_r == 8'hc9 || ctrue)) || is_pop || op_r == 8'he3) begin
      need_d0 = 1'b1;
      need_d1 = 1'b1;
      d0a = sp_r;
    end
  end

  // execute: compute next architectural state and writes
  logic [7:0] na, nb, nc, nd, ne, nh, nl;
  logic [15:0] nsp, npc;
  logic nz, ns, np, ncy, nac;
  logic [8:0] ar;
  logic [7:0] v8, av;
  logic [16:0] s17;
  logic [15:0] p16, pc1, pc2, pc3;

  always_comb begin
    na = a_r; nb = b_r; nc = c_r; nd = d_r; ne = e_r; nh = h_r; nl = l_r;
    nsp = sp_r;
    nz = fz_r; ns = fs_r; np = fp_r; ncy = fc_r; nac = fa_r;
    pc1 = pc_r + 16'd1;
    pc2 = pc_r + 16'd2;
    pc3 = pc_r + 16'd3;
    npc = pc1;
    nwr = 2'd0;
    w0a = hl; w0d = 8'h00; w1a = hl; w1d = 8'h00;
    ar = 9'd0; v8 = 8'h00; s17 = 17'd0; p16 = 16'd0;
    av = is_alui ? b1_r : rget(src, d0_r, b_r, c_r, d_r, e_r, h_r, l_r, a_r);
    if (is_mov || is_mvi) begin
      v8 = is_mvi ? b1_r : rget(src, d0_r, b_r, c_r, d_r, e_r, h_r, l_r, a_r);
      if (is_mvi) begin
        npc = pc2;
      end
      case (dst)
        3'd0: nb = v8;
        3'd1: nc = v8;
        3'd2: nd = v8;
        3'd3: ne = v8;
        3'd4: nh = v8;
        3'd5: nl = v8;
        3'd6: begin nwr = 2'd1; w0d = v8; end
        default: na = v8;
      endcase
    end else if (is_alu || is_alui) begin
      if (is_alui) begin
        npc = pc2;
      end
      case (cc)
        3'd0: ar = {1'b0, a_r} + {1'b0, av};
        3'd1: ar = {1'b0, a_r} + {1'b0, av} + {8'd0, fc_r};
        3'd2, 3'd7: ar = {1'b0, a_r} - {1'b0, av};
        3'd3: ar = {1'b0, a_r} - {1'b0, av} - {8'd0, fc_r};
        3'd4: ar = {1'b0, a_r & av};
        3'd5: ar = {1'b0, a_r ^ av};
        default: ar = {1'b0, a_r | av};
      endcase
      ncy = ar[8];
      nz = ar[7:0] == 8'h00;
      ns = ar[7];
      np = ebc_pkg::parity_even(ar[7:0]);
      if (cc != 3'd7) begin
        na = ar[7:0];
      end
    end else if (is_lxi) begin
      npc = pc3;
      case (rp)
        2'd0: begin nb = b2_r; nc = b1_r; end
        2'd1: begin nd = b2_r; ne = b1_r; end
        2'd2: begin nh = b2_r; nl = b1_r; end
        default: nsp = imm;
      endcase
    end else if ((op_r & 8'hcf) == 8'h09) begin
      s17 = {1'b0, hl} + {1'b0, pairv};
      ncy = s17[16];
      nh = s17[15:8];
      nl = s17[7:0];
    end else if ((op_r & 8'hcf) == 8'h03 || (op_r & 8'hcf) == 8'h0b) begin
      p16 = op_r[3] ? pairv - 16'd1 : pairv + 16'd1;
      case (rp)
        2'd0: begin nb = p16[15:8]; nc = p16[7:0]; end
        2'd1: begin nd = p16[15:8]; ne = p16[7:0]; end
        2'd2: begin nh = p16[15:8]; nl = p16[7:0]; end
        default: nsp = p16;
      endcase
    end else if (is_inr || is_dcr) begin
      v8 = rget(dst, d0_r, b_r, c_r, d_r, e_r, h_r, l_r, a_r);
      v8 = is_inr ? v8 + 8'd1 : v8 - 8'd1;
      nz = v8 == 8'h00;
      ns = v8[7];
      np = ebc_pkg::parity_even(v8);
      case (dst)
        3'd0: nb = v8;
        3'd1: nc = v8;
        3'd2: nd = v8;
        3'd3: ne = v8;
        3'd4: nh = v8;
        3'd5: nl = v8;
        3'd6: begin nwr = 2'd1; w0d = v8; end
        default: na = v8;
      endcase
    end else if (op_r[7:6] == 2'b00) begin
      case (op_r)
        8'h02, 8'h12: begin nwr = 2'd1; w0a = pairv; w0d = a_r; end
        8'h0a, 8'h1a: na = d0_r;
        8'h22: begin
          nwr = 2'd2; w0a = imm; w0d = l_r; w1a = imm + 16'd1; w1d = h_r; npc = pc3;
        end
        8'h2a: begin nl = d0_r; nh = rd_r; npc = pc3; end
        8'h32: begin nwr = 2'd1; w0a = imm; w0d = a_r; npc = pc3; end
        8'h3a: begin na = d0_r; npc = pc3; end
        8'h07: begin ncy = a_r[7]; na = {a_r[6:0], a_r[7]}; end
        8'h0f: begin ncy = a_r[0]; na = {a_r[0], a_r[7:1]}; end
        8'h17: begin ncy = a_r[7]; na = {a_r[6:0], fc_r}; end
        8'h1f: begin ncy = a_r[0]; na = {fc_r, a_r[7:1]}; end
        8'h2f: na = ~a_r;
        8'h37: ncy = 1'b1;
        8'h3f: ncy = ~fc_r;
        default: ;
      endcase
    end else if (is_ret) begin
      if (op_r == 8'hc9 || ctrue) begin
        npc = {rd_r, d0_r};
        nsp = sp_r + 16'd2;
      end
    end else if (is_jmpc || op_r == 8'hc3) begin
      npc = (op_r == 8'hc3 || ctrue) ? imm : pc3;
    end else if (is_callc || op_r == 8'hcd) begin
      npc = pc3;
      if (callt) begin
        nwr = 2'd2; w0a = sp_r - 16'd1; w0d = pc3[15:8];
        w1a = sp_r - 16'd2; w1d = pc3[7:0];
        nsp = sp_r - 16'd2; npc = imm;
      end
    end else if (is_rst) begin
      nwr = 2'd2; w0a = sp_r - 16'd1; w0d = pc1[15:8];
      w1a = sp_r - 16'd2; w1d = pc1[7:0];
      nsp = sp_r - 16'd2; npc = {8'h00, op_r & ebc_pkg::RST_MASK};
    end else if (is_pop) begin
      nsp = sp_r + 16'd2;
      case (rp)
        2'd0: begin nb = rd_r; nc = d0_r; end
        2'd1: begin nd = rd_r; ne = d0_r; end
        2'd2: begin nh = rd_r; nl = d0_r; end
        default: begin
          na = rd_r; ncy = d0_r[0]; np = d0_r[2]; nac = d0_r[4];
          nz = d0_r[6]; ns = d0_r[7];
        end
      endcase
    end else if (is_push) begin
      nwr = 2'd2; w0a = sp_r - 16'd1; w1a = sp_r - 16'd2; nsp = sp_r - 16'd2;
      if (rp == 2'd3) begin
        w0d = a_r;
        w1d = {fs_r, fz_r, 1'b0, fa_r, 1'b0, fp_r, 1'b1, fc_r};
      end else begin
        w0d = pairv[15:8]; w1d = pairv[7:0];
      end
    end else begin
      case (op_r)
        8'he3: begin
          nwr = 2'd2; w0a = sp_r; w0d = l_r; w1a = sp_r + 16'd1; w1d = h_r;
          nl = d0_r; nh = rd_r;
        end
        8'he9: npc = hl;
        8'heb: begin nh = d_r; nl = e_r; nd = h_r; ne = l_r; end
        8'hf9: nsp = hl;
        default: ;
      endcase
    end
  end

  logic unimpl;
  assign unimpl = op_r == 8'h76 || op_r == 8'h27 || op_r == 8'hd3 || op_r == 8'hdb
                  || op_r == 8'hf3 || op_r == 8'hfb;

  // write buffer for the execute stage
  logic [15:0] w1a_r;
  logic [7:0] w1d_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ebc_pkg::ST_IDLE: if (q_valid && !ov_r) begin
        if (q_cmd.func == ebc_pkg::FUNC_EXEC) st_nxt = ebc_pkg::ST_F0;
        else if (q_cmd.func == ebc_pkg::FUNC_READ) st_nxt = ebc_pkg::ST_F0;
        else st_nxt = ebc_pkg::ST_DONE;
      end
      ebc_pkg::ST_F0: st_nxt = ebc_pkg::ST_F1;
      ebc_pkg::ST_F1: st_nxt = cmd_r.func == ebc_pkg::FUNC_READ ? ebc_pkg::ST_DONE
                                                                 : ebc_pkg::ST_F2;
      ebc_pkg::ST_F2: st_nxt = ebc_pkg::ST_F3;
      ebc_pkg::ST_F3: st_nxt = need_d0 ? ebc_pkg::ST_D0 : ebc_pkg::ST_EXEC;
      ebc_pkg::ST_D0: st_nxt = ebc_pkg::ST_D1;
      ebc_pkg::ST_D1: st_nxt = need_d1 ? ebc_pkg::ST_D2 : ebc_pkg::ST_EXEC;
      ebc_pkg::ST_D2: st_nxt = ebc_pkg::ST_EXEC;
      ebc_pkg::ST_EXEC: st_nxt = nwr == 2'd2 ? ebc_pkg::ST_W1 : ebc_pkg::ST_DONE;
      ebc_pkg::ST_W1: st_nxt = ebc_pkg::ST_DONE;
      ebc_pkg::ST_DONE: st_nxt = ebc_pkg::ST_IDLE;
      default: st_nxt = ebc_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    maddr = pc_r;
    wdata = cmd_r.data;
    q_pop = 1'b0;
    case (st_r)
      ebc_pkg::ST_IDLE: begin
        q_pop = q_valid && !ov_r;
        maddr = q_cmd.address;
      end
      ebc_pkg::ST_F0: begin
        maddr = cmd_r.func == ebc_pkg::FUNC_READ ? cmd_r.address : pc_r;
      end
      ebc_pkg::ST_F1: maddr = pc_r + 16'd1;
      ebc_pkg::ST_F2: maddr = pc_r + 16'd2;
      ebc_pkg::ST_D0: maddr = d0a;
      ebc_pkg::ST_D1: maddr = d0a + 16'd1;
      ebc_pkg::ST_EXEC: begin
        we = nwr != 2'd0; maddr = w0a; wdata = w0d;
      end
      ebc_pkg::ST_W1: begin
        we = 1'b1; maddr = w1a_r; wdata = w1d_r;
      end
      ebc_pkg::ST_DONE: begin
        we = cmd_r.func == ebc_pkg::FUNC_WRITE; maddr = cmd_r.address;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ebc_pkg::ST_IDLE;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0; h_r <= '0; l_r <= '0;
      sp_r <= ebc_pkg::SP_RESET; pc_r <= '0;
      fz_r <= 1'b0; fs_r <= 1'b0; fp_r <= 1'b0; fc_r <= 1'b0; fa_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) begin
        ov_r <= 1'b0;
      end
      if (st_r == ebc_pkg::ST_DONE) begin
        ov_r <= 1'b1;
      end
      if (st_r == ebc_pkg::ST_EXEC) begin
        a_r <= na; b_r <= nb; c_r <= nc; d_r <= nd; e_r <= ne; h_r <= nh; l_r <= nl;
        sp_r <= nsp; pc_r <= npc;
        fz_r <= nz; fs_r <= ns; fp_r <= np; fc_r <= ncy; fa_r <= nac;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ebc_pkg::ST_IDLE: begin
        cmd_r <= q_cmd;
        rd_r <= 8'h00;
        un_r <= 1'b0;
      end
      ebc_pkg::ST_F1: begin
        op_r <= rdata;
        if (cmd_r.func == ebc_pkg::FUNC_READ) begin
          rd_r <= rdata;
        end
      end
      ebc_pkg::ST_F2: b1_r <= rdata;
      ebc_pkg::ST_F3: b2_r <= rdata;
      ebc_pkg::ST_D1: d0_r <= rdata;
      ebc_pkg::ST_D2: rd_r <= rdata;
      ebc_pkg::ST_EXEC: begin
        un_r <= unimpl;
        w1a_r <= w1a;
        w1d_r <= w1d;
        rd_r <= 8'h00;
      end
      default: ;
    endcase
  end

  // output register, loaded at the end of each item
  always_ff @(posedge clk) begin
    if (st_r == ebc_pkg::ST_DONE) begin
      out_pc <= pc_r; out_sp <= sp_r; out_acc <= a_r;
      out_bc <= {b_r, c_r}; out_de <= {d_r, e_r}; out_hl <= {h_r, l_r};
      out_psw <= {fs_r, fz_r, 1'b0, fa_r, 1'b0, fp_r, 1'b1, fc_r};
      out_read_data <= cmd_r.func == ebc_pkg::FUNC_READ ? rd_r : 8'h00;
      out_unimplemented <= cmd_r.func == ebc_pkg::FUNC_EXEC ? un_r : 1'b0;
    end
  end
  assign out_valid = ov_r;
endmodule

>>> hw/rtl/eight_bit_cpu_instruction_executor.sv
// channel  | handshake              | payload
// in       | in_valid / in_ready    | in_func, in_address, in_data
// out      | out_valid / out_ready  | out_pc .. out_read_data, out_unimplemented
// fetch, data reads and writes share the single memory port
// synchronous active-low reset; memory is not cleared
// a two-entry queue lets the input side keep taking items while the core runs
// a finished result waits in the output register; the core stalls until it is taken
module eight_bit_cpu_instruction_executor #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pc,
  output logic [15:0] out_sp,
  output logic [7:0]  out_acc,
  output logic [15:0] out_bc,
  output logic [15:0] out_de,
  output logic [15:0] out_hl,
  output logic [7:0]  out_psw,
  output logic [7:0]  out_read_data,
  output logic        out_unimplemented
);
  ebc_pkg::cmd_t q_cmd;
  logic q_valid, q_pop;

  ebc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .func(in_func), .address(in_address), .data(in_data),
    .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop)
  );

  ebc_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pc(out_pc), .out_sp(out_sp), .out_acc(out_acc), .out_bc(out_bc),
    .out_de(out_de), .out_hl(out_hl), .out_psw(out_psw),
    .out_read_data(out_read_data), .out_unimplemented(out_unimplemented)
  );
endmodule

>>> hw/rtl/ebc_checker.sv
`include "eight_bit_cpu_instruction_executor_defines.svh"
module ebc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_psw,
  input logic [7:0] out_read_data,
  input logic       out_unimplemented
);
  `EBC_ASSERT(a_psw_fixed, clk, rst_n, out_valid |-> (out_psw[1] && !out_psw[3] && !out_psw[5]), "psw bits")
  `EBC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `EBC_ASSERT(a_in_hold, clk, rst_n, (in_valid && !in_ready) |=> in_valid, "item dropped")
  `EBC_ASSERT(a_excl, clk, rst_n, out_valid |-> !(out_unimplemented && out_read_data != 8'h00), "excl")
  `EBC_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "result after reset")
endmodule

bind eight_bit_cpu_instruction_executor ebc_checker u_ebc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_psw(out_psw),
  .out_read_data(out_read_data), .out_unimplemented(out_unimplemented)
);

>>> bench/tb_eight_bit_cpu_instruction_executor.sv
module tb_eight_bit_cpu_instruction_executor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] OP_LXI_SP   = 8'h31;
  localparam logic [7:0] OP_DAD_SP   = 8'h39;
  localparam logic [7:0] OP_MVI_A    = 8'h3e;
  localparam logic [7:0] OP_MOV_M_A  = 8'h77;
  localparam logic [7:0] OP_ADI      = 8'hc6;
  localparam logic [7:0] OP_CPI      = 8'hfe;
  localparam logic [7:0] OP_CMP_A    = 8'hbf;
  localparam logic [7:0] OP_RAL      = 8'h17;
  localparam logic [7:0] OP_RRC      = 8'h0f;
  localparam logic [7:0] OP_CALL     = 8'hcd;
  localparam logic [7:0] OP_CNZ      = 8'hc4;
  localparam logic [7:0] OP_RET      = 8'hc9;
  localparam logic [7:0] OP_RST7     = 8'hff;
  localparam logic [7:0] OP_PUSH_PSW = 8'hf5;
  localparam logic [7:0] OP_POP_PSW  = 8'hf1;
  localparam logic [7:0] OP_XTHL     = 8'he3;
  localparam logic [7:0] OP_XCHG     = 8'heb;
  localparam logic [7:0] OP_PCHL     = 8'he9;
  localparam logic [7:0] OP_SPHL     = 8'hf9;
  localparam logic [7:0] OP_SHLD     = 8'h22;
  localparam logic [7:0] OP_LHLD     = 8'h2a;
  localparam logic [7:0] OP_STA      = 8'h32;
  localparam logic [7:0] OP_LDA      = 8'h3a;
  localparam logic [7:0] OP_STAX_B   = 8'h02;
  localparam logic [7:0] OP_STAX_D   = 8'h12;
  localparam logic [7:0] OP_LDAX_B   = 8'h0a;
  localparam logic [7:0] OP_LDAX_D   = 8'h1a;
  localparam logic [7:0] OP_RLC      = 8'h07;
  localparam logic [7:0] OP_RAR      = 8'h1f;
  localparam logic [7:0] OP_CMA      = 8'h2f;
  localparam logic [7:0] OP_STC      = 8'h37;
  localparam logic [7:0] OP_CMC      = 8'h3f;
  localparam logic [7:0] OP_JMP      = 8'hc3;
  localparam logic [7:0] OP_DAA      = 8'h27;
  localparam logic [7:0] OP_IN       = 8'hdb;
  localparam logic [7:0] OP_OUT      = 8'hd3;
  localparam logic [7:0] OP_EI       = 8'hfb;
  localparam logic [7:0] OP_DI       = 8'hf3;
  localparam logic [7:0] OP_HLT      = 8'h76;
  localparam logic [7:0] OP_UNDOC    = 8'hcb;
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam int ITEM_COUNT = 1350;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [15:0] pc, sp;
    logic [7:0]  acc;
    logic [15:0] bc, de, hl;
    logic [7:0]  psw, rd;
    logic        unimpl;
  } cpu_view_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [1:0] in_func = 0;
  logic [15:0] in_address = 0;
  logic [7:0] in_data = 0;
  logic out_valid, in_ready, out_unimplemented;
  logic [15:0] out_pc, out_sp, out_bc, out_de, out_hl;
  logic [7:0] out_acc, out_psw, out_read_data;

  eight_bit_cpu_instruction_executor dut (.*);

  logic [7:0] mem [65536];
  bit written [65536];
  logic [15:0] written_list [$];
  logic [7:0] ra, rb, rc, rd, re, rh, rl;
  logic [15:0] sp, pc;
  bit fz, fs, fp, fc, fa;

  cpu_view_t expected_views [$];
  int errors = 0, sent = 0, idle_cycles = 0;
  bit quiet = 0;

  initial forever #6 clk = ~clk;

  function automatic logic [15:0] hl_pair();
    return {rh, rl};
  endfunction

  function automatic logic [7:0] reg_read(logic [2:0] k);
    case (k)
      0: return rb;
      1: return rc;
      2: return rd;
      3: return re;
      4: return rh;
      5: return rl;
      6: return mem[hl_pair()];
      default: return ra;
    endcase
  endfunction

  function automatic void reg_write(logic [2:0] k, logic [7:0] v);
    case (k)
      0: rb = v;
      1: rc = v;
      2: rd = v;
      3: re = v;
      4: rh = v;
      5: rl = v;
      6: mem[hl_pair()] = v;
      default: ra = v;
    endcase
  endfunction

  function automatic logic [15:0] pair_read(logic [1:0] k);
    case (k)
      0: return {rb, rc};
      1: return {rd, re};
      2: return {rh, rl};
      default: return sp;
    endcase
  endfunction

  function automatic void pair_write(logic [1:0] k, logic [15:0] v);
    case (k)
      0: {rb, rc} = v;
      1: {rd, re} = v;
      2: {rh, rl} = v;
      default: sp = v;
    endcase
  endfunction

  function automatic void flags_zsp(logic [7:0] v);
    fz = (v == 8'd0);
    fs = v[7];
    fp = ~(^v);
  endfunction

  function automatic logic [7:0] psw_now();
    return {fs, fz, 1'b0, fa, 1'b0, fp, 1'b1, fc};
  endfunction

  function automatic void stack_push(logic [15:0] v);
    sp = sp - 16'd1;
    mem[sp] = v[15:8];
    sp = sp - 16'd1;
    mem[sp] = v[7:0];
  endfunction

  function automatic logic [15:0] stack_pop();
    logic [15:0] v;
    v = {mem[sp + 16'd1], mem[sp]};
    sp = sp + 16'd2;
    return v;
  endfunction

  function automatic void alu_apply(logic [2:0] k, logic [7:0] v);
    logic [8:0] r;
    case (k)
      0: r = {1'b0, ra} + {1'b0, v} + {8'd0, fc};
      1: r = {1'b0, ra} + {1'b0, v} + {8'd0, fc};
      2, 7: r = {1'b0, ra} - {1'b0, v};
      3: r = {1'b0, ra} - {1'b0, v} - {8'd0, fc};
      4: r = {1'b0, ra & v};
      5: r = {1'b0, ra ^ v};
      default: r = {1'b0, ra | v};
    endcase
    if (k == 3'd0) r = {1'b0, ra} + {1'b0, v};
    fc = r[8];
    flags_zsp(r[7:0]);
    if (k != 3'd7) ra = r[7:0];
  endfunction

  function automatic bit cond_met(logic [2:0] k);
    case (k)
      0: return !fz;
      1: return fz;
      2: return !fc;
      3: return fc;
      4: return !fp;
      5: return fp;
      6: return !fs;
      default: return fs;
    endcase
  endfunction

  function automatic bit execute_next();
    logic [7:0] op, b1, v, t;
    logic [15:0] imm, nxt;
    logic [16:0] s;
    logic [1:0] rp;
    logic [2:0] cc;
    bit unimpl;
    op = mem[pc];
    b1 = mem[pc + 16'd1];
    imm = {mem[pc + 16'd2], b1};
    nxt = pc + 16'd1;
    rp = op[5:4];
    cc = op[5:3];
    unimpl = 0;
    if (op[7:6] == 2'b01) begin
      if (op == OP_HLT) unimpl = 1;
      else reg_write(op[5:3], reg_read(op[2:0]));
    end else if (op[7:6] == 2'b10) begin
      alu_apply(op[5:3], reg_read(op[2:0]));
    end else if (op[7:6] == 2'b00) begin
      if (op[3:0] == 4'h1) begin
        pair_write(rp, imm);
        nxt = pc + 16'd3;
      end else if (op[3:0] == 4'h9) begin
        s = {1'b0, hl_pair()} + {1'b0, pair_read(rp)};
        fc = s[16];
        pair_write(2'd2, s[15:0]);
      end else if (op[3:0] == 4'h3) pair_write(rp, pair_read(rp) + 16'd1);
      else if (op[3:0] == 4'hb) pair_write(rp, pair_read(rp) - 16'd1);
      else if (op[2:0] == 3'd4 || op[2:0] == 3'd5) begin
        v = (op[0] == 1'b0) ? reg_read(cc) + 8'd1 : reg_read(cc) - 8'd1;
        flags_zsp(v);
        reg_write(cc, v);
      end else if (op[2:0] == 3'd6) begin
        reg_write(cc, b1);
        nxt = pc + 16'd2;
      end else begin
        case (op)
          OP_STAX_B, OP_STAX_D: mem[pair_read(rp)] = ra;
          OP_LDAX_B, OP_LDAX_D: ra = mem[pair_read(rp)];
          OP_SHLD: begin
            mem[imm] = rl;
            mem[imm + 16'd1] = rh;
            nxt = pc + 16'd3;
          end
          OP_LHLD: begin
            rl = mem[imm];
            rh = mem[imm + 16'd1];
            nxt = pc + 16'd3;
          end
          OP_STA: begin
            mem[imm] = ra;
            nxt = pc + 16'd3;
          end
          OP_LDA: begin
            ra = mem[imm];
            nxt = pc + 16'd3;
          end
          OP_RLC: begin
            fc = ra[7];
            ra = {ra[6:0], ra[7]};
          end
          OP_RRC: begin
            fc = ra[0];
            ra = {ra[0], ra[7:1]};
          end
          OP_RAL: begin
            t = {7'd0, fc};
            fc = ra[7];
            ra = {ra[6:0], t[0]};
          end
          OP_RAR: begin
            t = {7'd0, fc};
            fc = ra[0];
            ra = {t[0], ra[7:1]};
          end
          OP_DAA: unimpl = 1;
          OP_CMA: ra = ~ra;
          OP_STC: fc = 1;
          OP_CMC: fc = ~fc;
          default: ;
        endcase
      end
    end else begin
      if (op[2:0] == 3'd6) begin
        alu_apply(cc, b1);
        nxt = pc + 16'd2;
      end else if (op[2:0] == 3'd0) begin
        if (cond_met(cc)) nxt = stack_pop();
      end else if (op[2:0] == 3'd2) begin
        nxt = cond_met(cc) ? imm : pc + 16'd3;
      end else if (op[2:0] == 3'd4) begin
        if (cond_met(cc)) begin
          stack_push(pc + 16'd3);
          nxt = imm;
        end else nxt = pc + 16'd3;
      end else if (op[2:0] == 3'd7) begin
        stack_push(pc + 16'd1);
        nxt = {8'd0, op & ebc_pkg::RST_MASK};
      end else if (op[3:0] == 4'h1) begin
        imm = stack_pop();
        if (rp == 2'd3) begin
          ra = imm[15:8];
          fc = imm[0];
          fp = imm[2];
          fa = imm[4];
          fz = imm[6];
          fs = imm[7];
        end else pair_write(rp, imm);
      end else if (op[3:0] == 4'h5) begin
        if (rp == 2'd3) stack_push({ra, psw_now()});
        else stack_push(pair_read(rp));
      end else begin
        case (op)
          OP_JMP: nxt = imm;
          OP_RET: nxt = stack_pop();
          OP_CALL: begin
            stack_push(pc + 16'd3);
            nxt = imm;
          end
          OP_XTHL: begin
            v = mem[sp];
            t = mem[sp + 16'd1];
            mem[sp] = rl;
            mem[sp + 16'd1] = rh;
            rl = v;
            rh = t;
          end
          OP_PCHL: nxt = hl_pair();
          OP_XCHG: begin
            {rh, rl, rd, re} = {rd, re, rh, rl};
          end
          OP_SPHL: sp = hl_pair();
          OP_IN, OP_OUT, OP_EI, OP_DI: unimpl = 1;
          default: ;
        endcase
      end
    end
    pc = nxt;
    return unimpl;
  endfunction

  function automatic cpu_view_t apply_item(logic [1:0] f, logic [15:0] a, logic [7:0] d);
    cpu_view_t r;
    r.rd = 0;
    r.unimpl = 0;
    if (f == ebc_pkg::FUNC_WRITE) mem[a] = d;
    else if (f == ebc_pkg::FUNC_EXEC) r.unimpl = execute_next();
    else if (f == ebc_pkg::FUNC_READ) r.rd = mem[a];
    r.pc = pc;
    r.sp = sp;
    r.acc = ra;
    r.bc = {rb, rc};
    r.de = {rd, re};
    r.hl = {rh, rl};
    r.psw = psw_now();
    return r;
  endfunction

  task automatic send_item(logic [1:0] f, logic [15:0] a, logic [7:0] d);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_address <= a;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_views.push_back(apply_item(f, a, d));
    if (f == ebc_pkg::FUNC_WRITE && !written[a]) begin
      written[a] = 1;
      written_list.push_back(a);
    end
    sent++;
  endtask

  task automatic fill_if_blank(logic [15:0] a);
    if (!written[a]) send_item(ebc_pkg::FUNC_WRITE, a, 8'($urandom));
  endtask

  // places one instruction at pc with every byte it may read written, then runs it
  task automatic run_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2, int nbytes);
    logic [15:0] imm;
    imm = {b2, b1};
    fill_if_blank(hl_pair());
    fill_if_blank({rb, rc});
    fill_if_blank({rd, re});
    fill_if_blank(sp);
    fill_if_blank(sp + 16'd1);
    if (nbytes == 3) begin
      fill_if_blank(imm);
      fill_if_blank(imm + 16'd1);
    end
    send_item(ebc_pkg::FUNC_WRITE, pc, op);
    if (nbytes > 1) send_item(ebc_pkg::FUNC_WRITE, pc + 16'd1, b1);
    else fill_if_blank(pc + 16'd1);
    if (nbytes > 2) send_item(ebc_pkg::FUNC_WRITE, pc + 16'd2, b2);
    else fill_if_blank(pc + 16'd2);
    send_item(ebc_pkg::FUNC_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %h expected %h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cpu_view_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected item pc", out_pc, 16'd0);
      end else begin
        w = expected_views.pop_front();
        if (out_pc !== w.pc) report_mismatch("pc", out_pc, w.pc);
        if (out_sp !== w.sp) report_mismatch("sp", out_sp, w.sp);
        if (out_acc !== w.acc) report_mismatch("acc", 16'(out_acc), 16'(w.acc));
        if (out_bc !== w.bc) report_mismatch("bc", out_bc, w.bc);
        if (out_de !== w.de) report_mismatch("de", out_de, w.de);
        if (out_hl !== w.hl) report_mismatch("hl", out_hl, w.hl);
        if (out_psw !== w.psw) report_mismatch("psw", 16'(out_psw), 16'(w.psw));
        if (out_read_data !== w.rd)
          report_mismatch("read_data", 16'(out_read_data), 16'(w.rd));
        if (out_unimplemented !== w.unimpl)
          report_mismatch("unimplemented", 16'(out_unimplemented), 16'(w.unimpl));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (in_valid || expected_views.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("eight_bit_cpu_instruction_executor: mismatch");
      $finish;
    end
  end

  initial begin
    @(negedge clk);
    forever begin
      if (!rst_n || quiet || $urandom_range(0, 5) != 0) begin
        out_ready <= 1;
        @(negedge clk);
      end else begin
        out_ready <= 0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
    end
  end

  task automatic test_memory_port();
    send_item(ebc_pkg::FUNC_WRITE, 16'hffff, 8'hff);
    send_item(ebc_pkg::FUNC_READ, 16'hffff, 8'h00);
    send_item(ebc_pkg::FUNC_WRITE, 16'h8000, 8'h00);
    send_item(ebc_pkg::FUNC_READ, 16'h8000, 8'hff);
    send_item(FUNC_NONE, 16'h5555, 8'haa);
  endtask

  task automatic test_unimplemented();
    run_op(OP_DAA, 0, 0, 1);
    run_op(OP_IN, 8'h12, 0, 1);
    run_op(OP_OUT, 8'h34, 0, 1);
    run_op(OP_EI, 0, 0, 1);
    run_op(OP_DI, 0, 0, 1);
    run_op(OP_HLT, 0, 0, 1);
    run_op(OP_UNDOC, 0, 0, 1);
  endtask

  task automatic test_flags_and_stack();
    run_op(OP_MVI_A, 8'hff, 0, 2);
    run_op(OP_ADI, 8'h01, 0, 2);
    run_op(OP_CPI, 8'h01, 0, 2);
    run_op(OP_CMP_A, 0, 0, 1);
    run_op(OP_LXI_SP, 8'h01, 8'h00, 3);
    run_op(OP_DAD_SP, 0, 0, 1);
    run_op(OP_PUSH_PSW, 0, 0, 1);
    run_op(OP_POP_PSW, 0, 0, 1);
    run_op(OP_CNZ, 8'hfe, 8'hff, 3);
    run_op(OP_RST7, 0, 0, 1);
    run_op(OP_RET, 0, 0, 1);
  endtask

  task automatic test_random_programs();
    int pick;
    logic [15:0] a;
    while (sent < ITEM_COUNT) begin
      if (sent > ITEM_COUNT - 250) quiet = 1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_op(8'($urandom), 8'($urandom), 8'($urandom), 3);
      end else if (pick < 85) begin
        send_item(ebc_pkg::FUNC_WRITE, 16'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        a = written_list[$urandom_range(0, written_list.size() - 1)];
        send_item(ebc_pkg::FUNC_READ, a, 8'($urandom));
      end else begin
        send_item(FUNC_NONE, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    ra = 0; rb = 0; rc = 0; rd = 0; re = 0; rh = 0; rl = 0;
    sp = ebc_pkg::SP_RESET;
    pc = 0;
    fz = 0; fs = 0; fp = 0; fc = 0; fa = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    test_memory_port();
    test_unimplemented();
    test_flags_and_stack();
    test_random_programs();
    @(negedge clk);
    in_valid <= 0;
    wait_cycles = 0;
    while (expected_views.size() != 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_views.size() == 0) begin
      $display("eight_bit_cpu_instruction_executor: match");
    end else begin
      $display("eight_bit_cpu_instruction_executor: mismatch");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ebc_pkg.sv
hw/rtl/ebc_ram.sv
hw/rtl/ebc_front.sv
hw/rtl/ebc_back.sv
hw/rtl/eight_bit_cpu_instruction_executor.sv
hw/rtl/ebc_checker.sv
bench/tb_eight_bit_cpu_instruction_executor.sv
